>>> hdl/assert_macros.svh
// Assertion macros used by the connectivity generator RTL.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SCC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SCC_ASSERT(label, clk, rst, prop)
`define SCC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/scc_pkg.sv
// Types and constants of the structured cell connectivity generator.
// Used by scc_div and structured_cell_connectivity_gen.
package scc_pkg;
   localparam int DIV_W = 30;
   localparam int DIV_STEPS = 5;
   localparam int CNT_W = 11;

   localparam logic [2:0] ET_TRI   = 3'd0;
   localparam logic [2:0] ET_QUAD  = 3'd1;
   localparam logic [2:0] ET_TET   = 3'd2;
   localparam logic [2:0] ET_PRISM = 3'd3;
   localparam logic [2:0] ET_HEXA  = 3'd4;

   localparam logic [2:0] REG_TYPE  = 3'd0;
   localparam logic [2:0] REG_ORDER = 3'd1;
   localparam logic [2:0] REG_CX    = 3'd2;
   localparam logic [2:0] REG_CY    = 3'd3;
   localparam logic [2:0] REG_CZ    = 3'd4;

   typedef enum logic [3:0] {
      V_ID, V_FLIPIJ, V_FLIPIK, V_FLIPJK, V_E4, V_O0, V_O1, V_O2, V_O3, V_O4
   } var_type;

   typedef enum logic [2:0] {
      DS_EMPTY = 3'b001,
      DS_RUN   = 3'b010,
      DS_DONE  = 3'b100
   } div_state_type;

   typedef struct packed {
      logic [2:0] elem;
      logic [4:0] pos;
      logic       edone;
      logic       cdone;
      logic       err;
   } meta_type;
endpackage

>>> hdl/scc_div.sv
// Iterative restoring divider, several quotient bits per cycle.
// Depends on scc_pkg for widths and state codes.
module scc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [scc_pkg::DIV_W-1:0]      dividend,
   input  logic [scc_pkg::CNT_W-1:0]      divisor,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [scc_pkg::DIV_W-1:0]      quotient,
   output logic [scc_pkg::CNT_W-1:0]      remainder
);
   localparam int DW = scc_pkg::DIV_W;
   localparam int RW = scc_pkg::CNT_W;
   localparam int ITER = DW / scc_pkg::DIV_STEPS;
   localparam int IW = $clog2(ITER);

   scc_pkg::div_state_type state_ff, state_in;
   logic [DW-1:0] q_ff, q_in;
   logic [RW-1:0] r_ff, r_in;
   logic [RW-1:0] d_ff, d_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] qs;
   logic [RW-1:0] rs;
   logic [RW:0]   t;

   assign in_ready  = (state_ff == scc_pkg::DS_EMPTY);
   assign out_valid = (state_ff == scc_pkg::DS_DONE);
   assign quotient  = q_ff;
   assign remainder = r_ff;

   always_comb begin
      qs = q_ff;
      rs = r_ff;
      t  = '0;
      for (int b = 0; b < scc_pkg::DIV_STEPS; b++) begin
         t = {rs, qs[DW-1]};
         if (t >= {1'b0, d_ff}) begin
            rs = RW'(t - {1'b0, d_ff});
            qs = {qs[DW-2:0], 1'b1};
         end else begin
            rs = t[RW-1:0];
            qs = {qs[DW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         scc_pkg::DS_EMPTY: begin
            if (in_valid) begin
               q_in = dividend;
               r_in = '0;
               d_in = divisor;
               cnt_in = '0;
               state_in = scc_pkg::DS_RUN;
            end
         end
         scc_pkg::DS_RUN: begin
            q_in = qs;
            r_in = rs;
            cnt_in = IW'(cnt_ff + 1'b1);
            if (cnt_ff == IW'(ITER - 1)) state_in = scc_pkg::DS_DONE;
         end
         scc_pkg::DS_DONE: begin
            if (out_ready) state_in = scc_pkg::DS_EMPTY;
         end
         default: state_in = scc_pkg::DS_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::DS_EMPTY;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end
endmodule

>>> hdl/structured_cell_connectivity_gen.sv
// Structured grid element connectivity generator: cell number in, node numbers out.
// An accepted item passes through both dividers, the node sequencer and the registered
// node number pipeline; it gives N results (1 to 50). Each divider holds one item at a time.
// One result leaves per cycle while rsp_tready is high and the dividers keep up.
// Reset is synchronous and clears control state; the setup registers return to their reset values.
`include "assert_macros.svh"
module structured_cell_connectivity_gen #(
   parameter int MAX_CELLS_PER_AXIS = 1024,
   parameter int MAX_ORDER = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // cell_number[29:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // node_number, element_in_cell, node_in_element, element_done
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,  // range_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data
);
   localparam int RW = scc_pkg::CNT_W;
   localparam int DW = scc_pkg::DIV_W;

   logic [2:0] type_ff;
   logic [1:0] order_ff;
   logic [RW-1:0] cx_ff, cy_ff, cz_ff;
   logic [1:0] o;
   logic [RW-1:0] nx, ny, nz;
   logic [11:0] onx1, ony1;
   logic is3d;

   function automatic logic [10:0] clampc(input logic [10:0] v);
      return (int'(v) > MAX_CELLS_PER_AXIS) ? 11'(MAX_CELLS_PER_AXIS) : v;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= scc_pkg::ET_HEXA;
         order_ff <= 2'd1;
         cx_ff <= 11'd1;
         cy_ff <= 11'd1;
         cz_ff <= 11'd1;
      end else if (csr_valid) begin
         case (csr_index)
            scc_pkg::REG_TYPE:  type_ff <= csr_data[2:0];
            scc_pkg::REG_ORDER: order_ff <= csr_data[1:0];
            scc_pkg::REG_CX:    cx_ff <= csr_data;
            scc_pkg::REG_CY:    cy_ff <= csr_data;
            scc_pkg::REG_CZ:    cz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (order_ff == 2'd0) o = 2'd1;
      else if (int'(order_ff) > MAX_ORDER) o = 2'(MAX_ORDER);
      else o = order_ff;
   end
   assign nx = clampc(cx_ff);
   assign ny = clampc(cy_ff);
   assign nz = clampc(cz_ff);
   assign onx1 = 12'(12'(o) * 12'(nx) + 12'd1);
   assign ony1 = 12'(12'(o) * 12'(ny) + 12'd1);
   assign is3d = (type_ff >= scc_pkg::ET_TET);

   // Dividers: g / nx, then (g / nx) / ny.
   logic d1_ov, d1_or, d2_ir, d2_ov, d2_or;
   logic [DW-1:0] q1, q2;
   logic [RW-1:0] r1, r2;
   logic [DW-1:0] q1_ff;
   logic [RW-1:0] ci_hold_ff;

   scc_div u_div1 (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .dividend(req_tdata[DW-1:0]), .divisor(nx),
      .out_valid(d1_ov), .out_ready(d1_or),
      .quotient(q1), .remainder(r1)
   );
   assign d1_or = d2_ir;

   scc_div u_div2 (
      .clock(clock), .reset(reset),
      .in_valid(d1_ov), .in_ready(d2_ir),
      .dividend(q1), .divisor(ny),
      .out_valid(d2_ov), .out_ready(d2_or),
      .quotient(q2), .remainder(r2)
   );

   always_ff @(posedge clock) begin
      if (d1_ov && d2_ir) begin
         q1_ff <= q1;
         ci_hold_ff <= r1;
      end
   end

   // Node sequencer.
   logic en;
   assign en = !rsp_tvalid || rsp_tready;

   logic act_ff, act_in;
   logic [2:0] e_ff, e_in;
   logic [1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [4:0] pos_ff, pos_in;
   logic [RW-1:0] ci_ff, cj_ff, ck_ff;
   logic par_ff, err_ff;
   logic [2:0] nelem;
   logic kfull, jtri, itri;
   logic [1:0] kmax, jmax, imax, x, y, z;
   logic ilast, jlast, klast, elast, clast, step_last;
   logic [RW-1:0] cj_ld, ck_ld;
   logic err_ld;
   scc_pkg::var_type vsel;

   always_comb begin
      nelem = 3'd1;
      kfull = 1'b1;
      jtri = 1'b0;
      itri = 1'b0;
      case (type_ff)
         scc_pkg::ET_TRI:   begin nelem = 3'd2; kfull = 1'b0; itri = 1'b1; end
         scc_pkg::ET_QUAD:  begin kfull = 1'b0; end
         scc_pkg::ET_TET:   begin nelem = 3'd5; jtri = 1'b1; itri = 1'b1; end
         scc_pkg::ET_PRISM: begin nelem = 3'd2; itri = 1'b1; end
         default: ;
      endcase
   end

   always_comb begin
      vsel = scc_pkg::V_ID;
      if (type_ff == scc_pkg::ET_TET) begin
         case (e_ff)
            3'd0: vsel = par_ff ? scc_pkg::V_O0 : scc_pkg::V_ID;
            3'd1: vsel = par_ff ? scc_pkg::V_O1 : scc_pkg::V_FLIPIK;
            3'd2: vsel = par_ff ? scc_pkg::V_O2 : scc_pkg::V_FLIPJK;
            3'd3: vsel = par_ff ? scc_pkg::V_O3 : scc_pkg::V_FLIPIJ;
            default: vsel = par_ff ? scc_pkg::V_O4 : scc_pkg::V_E4;
         endcase
      end else if (e_ff == 3'd1) begin
         vsel = scc_pkg::V_FLIPIJ;
      end
   end

   always_comb begin
      case (vsel)
         scc_pkg::V_FLIPIJ: begin x = o - i_ff; y = o - j_ff; z = k_ff; end
         scc_pkg::V_FLIPIK: begin x = o - i_ff; y = j_ff; z = o - k_ff; end
         scc_pkg::V_FLIPJK: begin x = i_ff; y = o - j_ff; z = o - k_ff; end
         scc_pkg::V_E4: begin x = o - j_ff - k_ff; y = i_ff + j_ff; z = i_ff + k_ff; end
         scc_pkg::V_O0: begin x = i_ff + j_ff + k_ff; y = j_ff; z = k_ff; end
         scc_pkg::V_O1: begin x = o - j_ff; y = o - k_ff; z = i_ff + j_ff + k_ff; end
         scc_pkg::V_O2: begin x = j_ff; y = o - i_ff; z = k_ff; end
         scc_pkg::V_O3: begin x = i_ff; y = j_ff; z = i_ff + j_ff + k_ff; end
         scc_pkg::V_O4: begin x = i_ff + j_ff; y = j_ff + k_ff; z = k_ff + i_ff; end
         default: begin x = i_ff; y = j_ff; z = k_ff; end
      endcase
   end

   always_comb begin
      kmax = kfull ? o : 2'd0;
      jmax = jtri ? o - k_ff : o;
      imax = itri ? (jtri ? o - j_ff - k_ff : o - j_ff) : o;
      ilast = (i_ff == imax);
      jlast = (j_ff == jmax);
      klast = (k_ff == kmax);
      elast = ilast && jlast && klast;
      clast = elast && (e_ff == 3'(nelem - 3'd1));
      step_last = act_ff && (err_ff || clast);
   end

   assign d2_or = en && (!act_ff || step_last);

   always_comb begin
      cj_ld = is3d ? r2 : q1_ff[RW-1:0];
      ck_ld = is3d ? q2[RW-1:0] : '0;
      err_ld = (type_ff > scc_pkg::ET_HEXA) || (nx == '0) || (ny == '0)
             || (is3d ? ((nz == '0) || (q2 >= DW'(nz))) : (q1_ff >= DW'(ny)));
   end

   always_comb begin
      act_in = act_ff;
      e_in = e_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      pos_in = pos_ff;
      if (en && act_ff) begin
         pos_in = 5'(pos_ff + 5'd1);
         if (step_last) begin
            act_in = 1'b0;
         end else if (!ilast) begin
            i_in = i_ff + 2'd1;
         end else if (!jlast) begin
            i_in = '0;
            j_in = j_ff + 2'd1;
         end else if (!klast) begin
            i_in = '0;
            j_in = '0;
            k_in = k_ff + 2'd1;
         end else begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            pos_in = '0;
            e_in = 3'(e_ff + 3'd1);
         end
      end
      if (d2_ov && d2_or) begin
         act_in = 1'b1;
         e_in = '0;
         i_in = '0;
         j_in = '0;
         k_in = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
      e_ff <= e_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      pos_ff <= pos_in;
      if (d2_ov && d2_or) begin
         ci_ff <= ci_hold_ff;
         cj_ff <= cj_ld;
         ck_ff <= ck_ld;
         err_ff <= err_ld;
         par_ff <= ci_hold_ff[0] ^ cj_ld[0] ^ ck_ld[0];
      end
   end

   // Node number pipeline.
   logic v1_ff, v2_ff, v3_ff;
   scc_pkg::meta_type m0, m1_ff, m2_ff, m3_ff;
   logic [12:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, x3_ff;
   logic [24:0] a2_ff;
   logic [37:0] b3_ff;
   logic [33:0] node_ff;
   scc_pkg::meta_type mo_ff;

   always_comb begin
      m0.elem = err_ff ? 3'd0 : e_ff;
      m0.pos = err_ff ? 5'd0 : pos_ff;
      m0.edone = !err_ff && elast;
      m0.cdone = err_ff || clast;
      m0.err = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else if (en) begin
         v1_ff <= act_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         rsp_tvalid <= v3_ff;
      end
      if (en) begin
         m1_ff <= m0;
         x1_ff <= 13'(13'(o) * 13'(ci_ff) + 13'(x) + 13'd1);
         y1_ff <= 13'(13'(o) * 13'(cj_ff) + 13'(y));
         z1_ff <= 13'(13'(o) * 13'(ck_ff) + 13'(z));
         m2_ff <= m1_ff;
         a2_ff <= 25'(25'(ony1) * 25'(z1_ff));
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         m3_ff <= m2_ff;
         b3_ff <= 38'(38'(onx1) * 38'(a2_ff + 25'(y2_ff)));
         x3_ff <= x2_ff;
         mo_ff <= m3_ff;
         node_ff <= m3_ff.err ? 34'd0 : 34'(b3_ff + 38'(x3_ff));
      end
   end

   assign rsp_tdata = {5'd0, mo_ff.edone, mo_ff.pos, mo_ff.elem, node_ff};
   assign rsp_tlast = mo_ff.cdone;
   assign rsp_tuser = mo_ff.err;

   `SCC_ASSERT(a_err_single, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[33:0] == 34'd0))
   `SCC_ASSERT(a_elem_range, clock, reset, act_ff && !err_ff |-> e_ff < nelem)
   `SCC_ASSERT(a_last_elem, clock, reset, rsp_tvalid && rsp_tlast && !rsp_tuser[0] |-> rsp_tdata[42])
endmodule

>>> dv/tb_structured_cell_connectivity_gen.sv
// Self-checking testbench for structured_cell_connectivity_gen: sends cell numbers,
// predicts node-number items per grid setup and checks every returned item.
// Depends on scc_pkg and the RTL of structured_cell_connectivity_gen.
module tb_structured_cell_connectivity_gen;
   typedef struct {
      logic [33:0] node;
      logic [2:0]  elem;
      logic [4:0]  pos;
      logic        edone;
      logic        cdone;
      logic        err;
   } node_item_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [10:0] csr_data = '0;

   logic [2:0]  grid_type = scc_pkg::ET_HEXA;
   logic [1:0]  grid_order = 2'd1;
   logic [10:0] grid_cx = 11'd1;
   logic [10:0] grid_cy = 11'd1;
   logic [10:0] grid_cz = 11'd1;

   longint unsigned p_o, p_nx, p_ny, p_ci, p_cj, p_ck;
   node_item_type expected_nodes[$];
   int fail_count = 0;
   int items_sent = 0;
   int nodes_seen = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit idling_on = 1'b1;

   structured_cell_connectivity_gen u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned clamp_axis(logic [10:0] v);
      return (v > 11'd1024) ? 64'd1024 : 64'(v);
   endfunction

   function automatic void push_node(longint unsigned node, int unsigned e, int unsigned p,
                                     bit err);
      node_item_type r;
      r.node = node[33:0];
      r.elem = e[2:0];
      r.pos = p[4:0];
      r.edone = 1'b0;
      r.cdone = 1'b0;
      r.err = err;
      expected_nodes.push_back(r);
   endfunction

   function automatic void emit_element(int unsigned e, scc_pkg::var_type v, bit kfull,
                                        bit jtri, bit itri);
      longint unsigned i, j, k, x, y, z, kmax, jmax, imax;
      int unsigned p;
      p = 0;
      kmax = kfull ? p_o : 0;
      for (k = 0; k <= kmax; k++) begin
         jmax = jtri ? p_o - k : p_o;
         for (j = 0; j <= jmax; j++) begin
            imax = itri ? (jtri ? p_o - j - k : p_o - j) : p_o;
            for (i = 0; i <= imax; i++) begin
               case (v)
                  scc_pkg::V_FLIPIJ: begin x = p_o - i; y = p_o - j; z = k; end
                  scc_pkg::V_FLIPIK: begin x = p_o - i; y = j; z = p_o - k; end
                  scc_pkg::V_FLIPJK: begin x = i; y = p_o - j; z = p_o - k; end
                  scc_pkg::V_E4:     begin x = p_o - j - k; y = i + j; z = i + k; end
                  scc_pkg::V_O0:     begin x = i + j + k; y = j; z = k; end
                  scc_pkg::V_O1:     begin x = p_o - j; y = p_o - k; z = i + j + k; end
                  scc_pkg::V_O2:     begin x = j; y = p_o - i; z = k; end
                  scc_pkg::V_O3:     begin x = i; y = j; z = i + j + k; end
                  scc_pkg::V_O4:     begin x = i + j; y = j + k; z = k + i; end
                  default:           begin x = i; y = j; z = k; end
               endcase
               push_node(1 + p_o * p_ci + x + (p_o * p_nx + 1) *
                         (p_o * p_cj + y + (p_o * p_ny + 1) * (p_o * p_ck + z)), e, p, 1'b0);
               p++;
            end
         end
      end
      expected_nodes[$].edone = 1'b1;
   endfunction

   function automatic longint unsigned grid_cells();
      longint unsigned t;
      t = clamp_axis(grid_cx) * clamp_axis(grid_cy);
      if (grid_type >= scc_pkg::ET_TET) t = t * clamp_axis(grid_cz);
      return t;
   endfunction

   function automatic void predict_cell_nodes(logic [29:0] g);
      scc_pkg::var_type even_split[5] = '{scc_pkg::V_ID, scc_pkg::V_FLIPIK, scc_pkg::V_FLIPJK,
                                          scc_pkg::V_FLIPIJ, scc_pkg::V_E4};
      scc_pkg::var_type odd_split[5] = '{scc_pkg::V_O0, scc_pkg::V_O1, scc_pkg::V_O2,
                                         scc_pkg::V_O3, scc_pkg::V_O4};
      longint unsigned gl;
      gl = 64'(g);
      p_o = (grid_order == 2'd0) ? 1 : ((grid_order > 2'd2) ? 2 : 64'(grid_order));
      p_nx = clamp_axis(grid_cx);
      p_ny = clamp_axis(grid_cy);
      if (grid_type > scc_pkg::ET_HEXA || gl >= grid_cells()) begin
         push_node(0, 0, 0, 1'b1);
      end else begin
         p_ci = gl % p_nx;
         if (grid_type >= scc_pkg::ET_TET) begin
            p_cj = (gl / p_nx) % p_ny;
            p_ck = gl / (p_nx * p_ny);
         end else begin
            p_cj = gl / p_nx;
            p_ck = 0;
         end
         case (grid_type)
            scc_pkg::ET_TRI: begin
               emit_element(0, scc_pkg::V_ID, 0, 0, 1);
               emit_element(1, scc_pkg::V_FLIPIJ, 0, 0, 1);
            end
            scc_pkg::ET_QUAD: emit_element(0, scc_pkg::V_ID, 0, 0, 0);
            scc_pkg::ET_TET: begin
               for (int e = 0; e < 5; e++)
                  emit_element(e, ((p_ci + p_cj + p_ck) % 2 == 0) ? even_split[e] : odd_split[e],
                               1, 1, 1);
            end
            scc_pkg::ET_PRISM: begin
               emit_element(0, scc_pkg::V_ID, 1, 0, 1);
               emit_element(1, scc_pkg::V_FLIPIJ, 1, 0, 1);
            end
            default: emit_element(0, scc_pkg::V_ID, 1, 0, 0);
         endcase
      end
      expected_nodes[$].cdone = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      node_item_type exp_n;
      if (!reset && rsp_tvalid && rsp_tready) begin
         nodes_seen++;
         if (expected_nodes.size() == 0) begin
            $error("unexpected item: node_number %0d", rsp_tdata[33:0]);
            fail_count++;
         end else begin
            exp_n = expected_nodes.pop_front();
            if (rsp_tdata[33:0] !== exp_n.node) begin
               $error("node_number expected %0d got %0d", exp_n.node, rsp_tdata[33:0]);
               fail_count++;
            end
            if (rsp_tdata[36:34] !== exp_n.elem) begin
               $error("element_in_cell expected %0d got %0d", exp_n.elem, rsp_tdata[36:34]);
               fail_count++;
            end
            if (rsp_tdata[41:37] !== exp_n.pos) begin
               $error("node_in_element expected %0d got %0d", exp_n.pos, rsp_tdata[41:37]);
               fail_count++;
            end
            if (rsp_tdata[42] !== exp_n.edone) begin
               $error("element_done expected %0d got %0d", exp_n.edone, rsp_tdata[42]);
               fail_count++;
            end
            if (rsp_tlast !== exp_n.cdone) begin
               $error("cell_done expected %0d got %0d", exp_n.cdone, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser[0] !== exp_n.err) begin
               $error("range_error expected %0d got %0d", exp_n.err, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Watchdog expired with %0d items still expected.", expected_nodes.size());
      $display("FAILED: results differ");
      $finish;
   end

   // Leaves csr_valid high so that writes can follow back to back.
   task automatic write_reg(logic [2:0] idx, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         scc_pkg::REG_TYPE:  grid_type = value[2:0];
         scc_pkg::REG_ORDER: grid_order = value[1:0];
         scc_pkg::REG_CX:    grid_cx = value;
         scc_pkg::REG_CY:    grid_cy = value;
         scc_pkg::REG_CZ:    grid_cz = value;
         default: ;
      endcase
   endtask

   task automatic set_grid(logic [2:0] et, logic [1:0] ord, logic [10:0] cx, logic [10:0] cy,
                           logic [10:0] cz);
      write_reg(scc_pkg::REG_TYPE, 11'(et));
      write_reg(scc_pkg::REG_ORDER, 11'(ord));
      write_reg(scc_pkg::REG_CX, cx);
      write_reg(scc_pkg::REG_CY, cy);
      write_reg(scc_pkg::REG_CZ, cz);
      csr_valid <= 1'b0;
   endtask

   // Leaves req_tvalid high so that a following item can go out back to back.
   task automatic send_cell(logic [29:0] g);
      int gap;
      gap = (idling_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, g};
      do @(posedge clock); while (!req_tready);
      predict_cell_nodes(g);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_nodes.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_cell();
      longint unsigned t;
      t = grid_cells();
      if (t != 0 && grid_type <= scc_pkg::ET_HEXA && $urandom_range(0, 9) != 0)
         send_cell(30'($urandom_range(0, 32'(t - 1))));
      else
         send_cell(30'($urandom));
   endtask

   task automatic test_reset_defaults();
      send_cell(30'd0);
      send_cell(30'd1);
      send_cell(30'h3FFFFFFF);
      drain();
   endtask

   task automatic test_each_type();
      for (int et = 0; et <= 4; et++) begin
         for (int ord = 1; ord <= 2; ord++) begin
            set_grid(3'(et), 2'(ord), 11'd3, 11'd2, 11'd2);
            send_cell(30'd0);
            send_cell(30'd1);
            send_cell(30'd11);
            drain();
         end
      end
   endtask

   task automatic test_special_cases();
      set_grid(3'd5, 2'd1, 11'd2, 11'd2, 11'd2);
      send_cell(30'd0);
      drain();
      write_reg(scc_pkg::REG_TYPE, 11'd7);
      csr_valid <= 1'b0;
      send_cell(30'd3);
      drain();
      set_grid(scc_pkg::ET_QUAD, 2'd0, 11'd0, 11'd4, 11'd4);
      send_cell(30'd0);
      drain();
      set_grid(scc_pkg::ET_TET, 2'd3, 11'd2047, 11'd2, 11'd0);
      send_cell(30'd5);
      drain();
      set_grid(scc_pkg::ET_HEXA, 2'd2, 11'd2047, 11'd1024, 11'd1500);
      send_cell(30'h3FFFFFFF);
      send_cell(30'h2AAAAAAA);
      send_cell(30'h15555555);
      drain();
   endtask

   task automatic test_random_grids();
      logic [10:0] ax[3];
      for (int ph = 0; ph < 12; ph++) begin
         for (int a = 0; a < 3; a++) begin
            case ($urandom_range(0, 9))
               0: ax[a] = 11'd0;
               1: ax[a] = 11'($urandom_range(1000, 2047));
               default: ax[a] = 11'($urandom_range(1, 8));
            endcase
         end
         if (ph == 11) begin
            idling_on = 1'b0;
            ax = '{11'd1024, 11'd1024, 11'd1024};
         end
         set_grid(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4)),
                  2'($urandom_range(0, 3)), ax[0], ax[1], ax[2]);
         repeat (32) send_random_cell();
         drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_each_type();
      test_special_cases();
      test_random_grids();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered all element types, both orders, range errors and clamped setups:");
      $display("  %0d cell items sent, %0d node items checked.", items_sent, nodes_seen);
      if (fail_count == 0 && expected_nodes.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
